// ----- sv/cle_pkg.sv -----
package cle_pkg;

    // pool geometry
    localparam int CAPACITY   = 32;
    localparam int VALUE_BITS = 32;
    localparam int SLOT_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // stream field widths
    localparam int CMD_W       = 3;
    localparam int VAL_W       = 32;
    localparam int POS_W       = 8;
    localparam int STATUS_W    = 2;
    localparam int INDEX_W     = 6;
    localparam int IN_TDATA_W  = ((VAL_W + POS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((VAL_W + INDEX_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_END   = 3'd0,
        CMD_INS_BEGIN = 3'd1,
        CMD_INS_POS   = 3'd2,
        CMD_DEL_BEGIN = 3'd3,
        CMD_DEL_END   = 3'd4,
        CMD_DEL_VALUE = 3'd5,
        CMD_READ_OUT  = 3'd6
    } t_cmd;

    // command code with no meaning, dropped without a result
    localparam logic [CMD_W-1:0] CMD_IGNORED = 3'd7;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_SCAN,
        S_WR_A,
        S_WR_B,
        S_EMIT
    } t_state;

    // request from the sequencer to the entry memories
    typedef struct packed {
        logic                  rd_en;
        logic [SLOT_W-1:0]     rd_addr;
        logic                  val_we;
        logic [SLOT_W-1:0]     val_waddr;
        logic [VALUE_BITS-1:0] val_wdata;
        logic                  lnk_we;
        logic [SLOT_W-1:0]     lnk_waddr;
        logic [SLOT_W-1:0]     lnk_wdata;
    } t_mem_req;

    // input value into the stored width
    function automatic logic [VALUE_BITS-1:0] to_store(input logic signed [VAL_W-1:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        return w[VALUE_BITS-1:0];
    endfunction

    // stored value back to the output width
    function automatic logic [VAL_W-1:0] to_out(input logic [VALUE_BITS-1:0] s);
        logic signed [63:0] w;
        w = 64'($signed(s));
        return w[VAL_W-1:0];
    endfunction

    // link follow, out-of-range links point at slot zero
    function automatic logic [SLOT_W-1:0] nxt_slot(input logic [SLOT_W-1:0] l);
        return (CNT_W'(l) < CNT_W'(CAPACITY)) ? l : '0;
    endfunction

endpackage

// ----- sv/cle_alloc.sv -----
module cle_alloc (
    input  logic [cle_pkg::CAPACITY-1:0] i_free,
    output logic [cle_pkg::SLOT_W-1:0]   o_slot
);

    // lowest free slot, last slot when none is free
    always_comb begin
        o_slot = cle_pkg::SLOT_W'(cle_pkg::CAPACITY - 1);
        for (int i = cle_pkg::CAPACITY - 2; i >= 0; i--) begin
            if (i_free[i]) begin
                o_slot = cle_pkg::SLOT_W'(i);
            end
        end
    end

endmodule

// ----- sv/cle_store.sv -----
module cle_store (
    input  logic                           i_clk,
    input  cle_pkg::t_mem_req              i_req,
    output logic [cle_pkg::VALUE_BITS-1:0] o_rd_val,
    output logic [cle_pkg::SLOT_W-1:0]     o_rd_link
);

    logic [cle_pkg::VALUE_BITS-1:0] r_val_mem [cle_pkg::CAPACITY];
    logic [cle_pkg::SLOT_W-1:0]     r_lnk_mem [cle_pkg::CAPACITY];

    // write ports
    always_ff @(posedge i_clk) begin
        if (i_req.val_we) begin
            r_val_mem[i_req.val_waddr] <= i_req.val_wdata;
        end
        if (i_req.lnk_we) begin
            r_lnk_mem[i_req.lnk_waddr] <= i_req.lnk_wdata;
        end
    end

    // shared read address, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            o_rd_val  <= r_val_mem[i_req.rd_addr];
            o_rd_link <= r_lnk_mem[i_req.rd_addr];
        end
    end

endmodule

// ----- sv/cle_ctrl.sv -----
module cle_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [cle_pkg::CMD_W-1:0]      i_cmd,
    input  logic signed [cle_pkg::VAL_W-1:0] i_value,
    input  logic [cle_pkg::POS_W-1:0]      i_pos,
    output cle_pkg::t_mem_req              o_req,
    input  logic [cle_pkg::VALUE_BITS-1:0] i_rd_val,
    input  logic [cle_pkg::SLOT_W-1:0]     i_rd_link,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [cle_pkg::STATUS_W-1:0]   o_status,
    output logic [cle_pkg::VAL_W-1:0]      o_result,
    output logic [cle_pkg::INDEX_W-1:0]    o_index,
    output logic                           o_last
);

    localparam int SW = cle_pkg::SLOT_W;
    localparam int CW = cle_pkg::CNT_W;
    localparam int PW = cle_pkg::POS_W;

    cle_pkg::t_state r_state, n_state;

    // latched item
    cle_pkg::t_cmd                  r_cmd, n_cmd;
    logic [cle_pkg::VALUE_BITS-1:0] r_val, n_val;
    logic [PW-1:0]                  r_pos, n_pos;
    logic [SW-1:0]                  r_slot, n_slot;
    logic                           r_empty_ins, n_empty_ins;

    // list state
    logic [cle_pkg::CAPACITY-1:0] r_free, n_free;
    logic [SW-1:0]                r_tail, n_tail;
    logic [CW-1:0]                r_count, n_count;

    // walk state
    logic [SW-1:0] r_cur, n_cur;
    logic [SW-1:0] r_prev, n_prev;
    logic [SW-1:0] r_pred, n_pred;
    logic [SW-1:0] r_succ, n_succ;
    logic          r_set_tail, n_set_tail;
    logic [PW-1:0] r_steps, n_steps;
    logic [CW-1:0] r_idx, n_idx;

    // pending single result
    cle_pkg::t_status       r_res_status, n_res_status;
    logic [cle_pkg::VAL_W-1:0] r_res_value, n_res_value;

    // output register
    logic                         r_out_valid, n_out_valid;
    logic [cle_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic [cle_pkg::VAL_W-1:0]    r_out_value, n_out_value;
    logic [cle_pkg::INDEX_W-1:0]  r_out_index, n_out_index;
    logic                         r_out_last, n_out_last;

    logic [SW-1:0] w_alloc;
    logic          w_accept;
    logic          w_out_free;
    logic [SW-1:0] w_link;
    logic          w_match;
    logic [CW-1:0] w_idx_inc;

    cle_alloc u_alloc (
        .i_free (r_free),
        .o_slot (w_alloc)
    );

    assign o_in_ready  = (r_state == cle_pkg::S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_link      = cle_pkg::nxt_slot(i_rd_link);
    assign w_idx_inc   = r_idx + 1'b1;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_result    = r_out_value;
    assign o_index     = r_out_index;
    assign o_last      = r_out_last;

    // delete target test on the entry just read
    always_comb begin
        unique case (r_cmd)
            cle_pkg::CMD_DEL_BEGIN: w_match = 1'b1;
            cle_pkg::CMD_DEL_END:   w_match = (r_cur == r_tail);
            default:                w_match = (i_rd_val == r_val);
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cle_pkg::S_IDLE;
            r_free      <= '1;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free      <= n_free;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_val        <= n_val;
        r_pos        <= n_pos;
        r_slot       <= n_slot;
        r_empty_ins  <= n_empty_ins;
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_pred       <= n_pred;
        r_succ       <= n_succ;
        r_set_tail   <= n_set_tail;
        r_steps      <= n_steps;
        r_idx        <= n_idx;
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_index  <= n_out_index;
        r_out_last   <= n_out_last;
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_val        = r_val;
        n_pos        = r_pos;
        n_slot       = r_slot;
        n_empty_ins  = r_empty_ins;
        n_free       = r_free;
        n_tail       = r_tail;
        n_count      = r_count;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_pred       = r_pred;
        n_succ       = r_succ;
        n_set_tail   = r_set_tail;
        n_steps      = r_steps;
        n_idx        = r_idx;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_index  = r_out_index;
        n_out_last   = r_out_last;
        n_out_valid  = (r_out_valid && !i_out_ready);

        o_req           = '0;
        o_req.rd_addr   = r_tail;
        o_req.val_waddr = r_slot;
        o_req.val_wdata = r_val;
        o_req.lnk_waddr = r_slot;
        o_req.lnk_wdata = r_succ;

        unique case (r_state)
            cle_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_cmd        = cle_pkg::t_cmd'(i_cmd);
                    n_val        = cle_pkg::to_store(i_value);
                    n_pos        = i_pos;
                    n_slot       = w_alloc;
                    n_empty_ins  = (r_count == '0);
                    n_res_value  = '0;
                    n_res_status = cle_pkg::ST_OK;
                    unique case (cle_pkg::t_cmd'(i_cmd))
                        cle_pkg::CMD_INS_END, cle_pkg::CMD_INS_BEGIN,
                        cle_pkg::CMD_INS_POS: begin
                            if (r_count == CW'(cle_pkg::CAPACITY)) begin
                                n_res_status = cle_pkg::ST_FULL;
                                n_state      = cle_pkg::S_EMIT;
                            end else if (r_count == '0) begin
                                n_state = cle_pkg::S_WR_A;
                            end else begin
                                o_req.rd_en = 1'b1;
                                n_state     = cle_pkg::S_HEAD;
                            end
                        end
                        cle_pkg::CMD_DEL_BEGIN, cle_pkg::CMD_DEL_END,
                        cle_pkg::CMD_DEL_VALUE, cle_pkg::CMD_READ_OUT: begin
                            if (r_count == '0) begin
                                n_res_status = cle_pkg::ST_EMPTY;
                                n_state      = cle_pkg::S_EMIT;
                            end else begin
                                o_req.rd_en = 1'b1;
                                n_state     = cle_pkg::S_HEAD;
                            end
                        end
                        default: begin
                            n_state = cle_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            // tail link read back: w_link is the head
            cle_pkg::S_HEAD: begin
                n_prev = r_tail;
                n_idx  = '0;
                if (r_cmd == cle_pkg::CMD_INS_POS && r_pos > PW'(1)
                        && r_pos <= PW'(r_count)) begin
                    // walk to the entry in front of the new one
                    o_req.rd_en   = 1'b1;
                    o_req.rd_addr = w_link;
                    n_cur         = w_link;
                    n_steps       = r_pos - PW'(2);
                    n_state       = cle_pkg::S_SCAN;
                end else if (r_cmd == cle_pkg::CMD_INS_END || r_cmd == cle_pkg::CMD_INS_BEGIN
                        || r_cmd == cle_pkg::CMD_INS_POS) begin
                    // splice in behind the tail
                    n_pred     = r_tail;
                    n_succ     = w_link;
                    n_set_tail = (r_cmd == cle_pkg::CMD_INS_END)
                                 || (r_cmd == cle_pkg::CMD_INS_POS && r_pos > PW'(1));
                    n_state    = cle_pkg::S_WR_A;
                end else begin
                    o_req.rd_en   = 1'b1;
                    o_req.rd_addr = w_link;
                    n_cur         = w_link;
                    n_state       = cle_pkg::S_SCAN;
                end
            end

            // one entry per cycle, read-out only while the output is free, data of r_cur on the read port
            cle_pkg::S_SCAN: begin
                unique case (r_cmd)
                    cle_pkg::CMD_INS_END, cle_pkg::CMD_INS_BEGIN, cle_pkg::CMD_INS_POS: begin
                        if (r_steps == '0) begin
                            n_pred     = r_cur;
                            n_succ     = w_link;
                            n_set_tail = 1'b0;
                            n_state    = cle_pkg::S_WR_A;
                        end else begin
                            o_req.rd_en   = 1'b1;
                            o_req.rd_addr = w_link;
                            n_cur         = w_link;
                            n_steps       = r_steps - 1'b1;
                        end
                    end
                    cle_pkg::CMD_READ_OUT: begin
                        if (w_out_free) begin
                            n_out_valid  = 1'b1;
                            n_out_status = cle_pkg::ST_OK;
                            n_out_value  = cle_pkg::to_out(i_rd_val);
                            n_out_index  = cle_pkg::INDEX_W'(w_idx_inc);
                            n_out_last   = (w_idx_inc == r_count);
                            if (w_idx_inc == r_count) begin
                                n_state = cle_pkg::S_IDLE;
                            end else begin
                                o_req.rd_en   = 1'b1;
                                o_req.rd_addr = w_link;
                                n_cur         = w_link;
                                n_idx         = w_idx_inc;
                            end
                        end
                    end
                    default: begin
                        if (w_match) begin
                            // unlink r_cur, r_prev takes over its link
                            if (r_count > CW'(1)) begin
                                o_req.lnk_we    = 1'b1;
                                o_req.lnk_waddr = r_prev;
                                o_req.lnk_wdata = w_link;
                                if (r_cur == r_tail) begin
                                    n_tail = r_prev;
                                end
                            end else begin
                                n_tail = '0;
                            end
                            n_free[r_cur] = 1'b1;
                            n_count       = r_count - 1'b1;
                            n_res_value   = cle_pkg::to_out(i_rd_val);
                            n_state       = cle_pkg::S_EMIT;
                        end else if (w_idx_inc == r_count) begin
                            n_res_status = cle_pkg::ST_NOT_FOUND;
                            n_state      = cle_pkg::S_EMIT;
                        end else begin
                            o_req.rd_en   = 1'b1;
                            o_req.rd_addr = w_link;
                            n_prev        = r_cur;
                            n_cur         = w_link;
                            n_idx         = w_idx_inc;
                        end
                    end
                endcase
            end

            // new entry: value and forward link
            cle_pkg::S_WR_A: begin
                o_req.val_we = 1'b1;
                o_req.lnk_we = 1'b1;
                if (r_empty_ins) begin
                    o_req.lnk_wdata = r_slot;
                    n_tail          = r_slot;
                    n_free[r_slot]  = 1'b0;
                    n_count         = r_count + 1'b1;
                    n_state         = cle_pkg::S_EMIT;
                end else begin
                    n_state = cle_pkg::S_WR_B;
                end
            end

            // predecessor now points at the new entry
            cle_pkg::S_WR_B: begin
                o_req.lnk_we    = 1'b1;
                o_req.lnk_waddr = r_pred;
                o_req.lnk_wdata = r_slot;
                if (r_set_tail) begin
                    n_tail = r_slot;
                end
                n_free[r_slot] = 1'b0;
                n_count        = r_count + 1'b1;
                n_state        = cle_pkg::S_EMIT;
            end

            cle_pkg::S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_value  = r_res_value;
                    n_out_index  = '0;
                    n_out_last   = 1'b1;
                    n_state      = cle_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = cle_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/circular_list_engine.sv -----
// Circular singly linked list of signed values in a pool of 32 entries. Each input word carries
// a command in tuser (insert at end, at head or at a 1-based position, delete head, delete
// tail, delete first matching value, read out) and a value and position in tdata; every valid
// command but read-out answers with one word, read-out with one word per entry head first and
// tlast on the final one, and a rejected command (empty list, pool full, value not found)
// answers with one word whose status is in tuser. The block takes one command at a time and is
// busy until that command's work is done. Cost is set by the link walk through the entry
// memory, one registered read per cycle while the output side keeps up: an insert reads the
// tail link, walks to the entry in front of the new one for a positional insert inside the
// list, then writes the new entry and its predecessor's link (only the entry for an empty
// list); deletes and searches walk from the head to the match or the tail, read-out emits each
// entry as it is read, and a command refused at once (pool full, empty list) is answered directly.
// A new entry always takes the lowest free slot; no clearing pass is run after reset.
module circular_list_engine (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [cle_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // value[31:0], position[39:32]
    input  logic [cle_pkg::CMD_W-1:0]       s_axis_tuser,  // command[2:0]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [cle_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // result_value[31:0], entry_index[37:32]
    output logic [cle_pkg::STATUS_W-1:0]    m_axis_tuser,  // status[1:0]
    output logic                            m_axis_tlast
);

    cle_pkg::t_mem_req              w_req;
    logic [cle_pkg::VALUE_BITS-1:0] w_rd_val;
    logic [cle_pkg::SLOT_W-1:0]     w_rd_link;
    logic [cle_pkg::VAL_W-1:0]      w_result;
    logic [cle_pkg::INDEX_W-1:0]    w_index;

    cle_store u_store (
        .i_clk     (i_clk),
        .i_req     (w_req),
        .o_rd_val  (w_rd_val),
        .o_rd_link (w_rd_link)
    );

    cle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_cmd       (s_axis_tuser),
        .i_value     ($signed(s_axis_tdata[cle_pkg::VAL_W-1:0])),
        .i_pos       (s_axis_tdata[cle_pkg::VAL_W +: cle_pkg::POS_W]),
        .o_req       (w_req),
        .i_rd_val    (w_rd_val),
        .i_rd_link   (w_rd_link),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_status    (m_axis_tuser),
        .o_result    (w_result),
        .o_index     (w_index),
        .o_last      (m_axis_tlast)
    );

    // pack result word, zero pad to whole bytes
    assign m_axis_tdata = cle_pkg::OUT_TDATA_W'({w_index, w_result});

endmodule

// ----- sv/cle_checker.sv -----
module cle_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [cle_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic [cle_pkg::CMD_W-1:0]       s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [cle_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [cle_pkg::STATUS_W-1:0]    m_axis_tuser,
    input logic                            m_axis_tlast
);

    // output word holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // nothing pending right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // an error status is a single word with no payload
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != cle_pkg::ST_OK |->
            m_axis_tlast && m_axis_tdata == '0)
        else $error("error status word malformed");

    // a real command keeps the block busy the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser != cle_pkg::CMD_IGNORED
            |=> !s_axis_tready)
        else $error("ready right after accepting a command");

endmodule

bind circular_list_engine cle_checker u_cle_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ----- test/tb_circular_list_engine.sv -----
`timescale 1ns / 1ps

module tb_circular_list_engine;

    localparam int RX_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 80;

    typedef struct {
        logic [cle_pkg::CMD_W-1:0]        cmd;
        logic signed [cle_pkg::VAL_W-1:0] value;
        logic [cle_pkg::POS_W-1:0]        position;
        bit                               wait_drain;
    } t_list_word;

    typedef struct {
        cle_pkg::t_status                 status;
        logic signed [cle_pkg::VAL_W-1:0] value;
        logic [cle_pkg::INDEX_W-1:0]      index;
        logic                             last;
    } t_list_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [cle_pkg::IN_TDATA_W-1:0]  s_tdata = '0;   // value[31:0], position[39:32]
    logic [cle_pkg::CMD_W-1:0]       s_tuser = '0;   // command[2:0]
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [cle_pkg::OUT_TDATA_W-1:0] m_tdata;        // result_value[31:0], entry_index[37:32]
    logic [cle_pkg::STATUS_W-1:0]    m_tuser;        // status[1:0]
    logic                            m_tlast;

    t_list_word                       word_q[$];
    t_list_result                     results_q[$];
    logic signed [cle_pkg::VAL_W-1:0] chain_q[$];    // list contents, head first

    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    int  rx_hold_asks = 0;
    int  rx_holds_done = 0;
    int  rx_hold_left = 0;
    int  idle_cycles = 0;
    int  n_fail = 0;
    logic in_hs = 1'b0;

    circular_list_engine uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // list behavior: expected result words for one accepted command
    function automatic void predict_list_op(input logic [cle_pkg::CMD_W-1:0] cmd,
                                            input logic signed [cle_pkg::VAL_W-1:0] v,
                                            input logic [cle_pkg::POS_W-1:0] pos);
        int n;
        int hit;
        n = chain_q.size();
        hit = -1;
        if (cmd == cle_pkg::CMD_IGNORED)
            return;
        if (cmd == cle_pkg::CMD_INS_END || cmd == cle_pkg::CMD_INS_BEGIN
                || cmd == cle_pkg::CMD_INS_POS) begin
            if (n >= cle_pkg::CAPACITY) begin
                results_q.push_back('{cle_pkg::ST_FULL, 0, 0, 1'b1});
                return;
            end
            // positional insert inside the list, else at the tail or the head
            if (cmd == cle_pkg::CMD_INS_POS && pos > 1 && n > 0 && int'(pos) <= n)
                chain_q.insert(int'(pos) - 1, v);
            else if (cmd == cle_pkg::CMD_INS_END || (cmd == cle_pkg::CMD_INS_POS && pos > 1))
                chain_q.push_back(v);
            else
                chain_q.push_front(v);
            results_q.push_back('{cle_pkg::ST_OK, 0, 0, 1'b1});
            return;
        end
        if (n == 0) begin
            results_q.push_back('{cle_pkg::ST_EMPTY, 0, 0, 1'b1});
            return;
        end
        case (cmd)
            cle_pkg::CMD_DEL_BEGIN: begin
                results_q.push_back('{cle_pkg::ST_OK, chain_q[0], 0, 1'b1});
                chain_q.delete(0);
            end
            cle_pkg::CMD_DEL_END: begin
                results_q.push_back('{cle_pkg::ST_OK, chain_q[n-1], 0, 1'b1});
                chain_q.delete(n - 1);
            end
            cle_pkg::CMD_DEL_VALUE: begin
                for (int i = 0; i < n && hit < 0; i++)
                    if (chain_q[i] == v)
                        hit = i;
                if (hit < 0) begin
                    results_q.push_back('{cle_pkg::ST_NOT_FOUND, 0, 0, 1'b1});
                end else begin
                    results_q.push_back('{cle_pkg::ST_OK, chain_q[hit], 0, 1'b1});
                    chain_q.delete(hit);
                end
            end
            default: begin
                for (int i = 0; i < n; i++)
                    results_q.push_back('{cle_pkg::ST_OK, chain_q[i],
                                          cle_pkg::INDEX_W'(i + 1), i == n - 1});
            end
        endcase
    endfunction

    function automatic t_list_word make_word(input logic [cle_pkg::CMD_W-1:0] cmd,
                                             input logic signed [cle_pkg::VAL_W-1:0] v,
                                             input logic [cle_pkg::POS_W-1:0] pos);
        t_list_word w;
        w.cmd = cmd;
        w.value = v;
        w.position = pos;
        w.wait_drain = 1'b0;
        return w;
    endfunction

    // random command; small values so that searches hit, sometimes full range
    function automatic t_list_word rand_word(input int ins_pct);
        t_list_word w;
        int r;
        r = $urandom_range(0, 99);
        if (r < ins_pct)
            w.cmd = cle_pkg::CMD_W'($urandom_range(0, 2));
        else if (r < 97)
            w.cmd = cle_pkg::CMD_W'($urandom_range(3, 6));
        else
            w.cmd = cle_pkg::CMD_IGNORED;
        if ($urandom_range(0, 9) < 6) begin
            w.value = $urandom_range(0, 15);
            w.value = w.value - 8;
        end else begin
            w.value = $urandom;
        end
        if ($urandom_range(0, 4) == 0)
            w.position = cle_pkg::POS_W'($urandom);
        else
            w.position = cle_pkg::POS_W'($urandom_range(0, 12));
        w.wait_drain = 1'b0;
        return w;
    endfunction

    task automatic drain_words();
        while (word_q.size() > 0)
            @(posedge i_clk);
    endtask

    // input driver, words change on the falling edge
    always @(negedge i_clk) begin : drive_words
        t_list_word w;
        if (i_rst_n && (!s_tvalid || in_hs)) begin
            if (word_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct &&
                !(word_q[0].wait_drain && results_q.size() > 0)) begin
                w = word_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {w.position, w.value};
                s_tuser  <= w.cmd;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // output back-pressure, with a long hold on request
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            m_tready <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else if (rx_holds_done < rx_hold_asks) begin
            m_tready <= 1'b0;
            rx_holds_done <= rx_holds_done + 1;
            rx_hold_left <= RX_HOLD_CYCLES;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // accepted words: predict inputs, check outputs, watchdog
    always @(posedge i_clk) begin : watch_words
        t_list_result e;
        if (!i_rst_n) begin
            in_hs <= 1'b0;
        end else begin
            in_hs <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                predict_list_op(s_tuser, s_tdata[cle_pkg::VAL_W-1:0],
                                s_tdata[cle_pkg::VAL_W+cle_pkg::POS_W-1:cle_pkg::VAL_W]);
            if (m_tvalid && m_tready) begin
                if (results_q.size() == 0) begin
                    $error("unexpected result word: status %0d value %0d", m_tuser,
                           $signed(m_tdata[cle_pkg::VAL_W-1:0]));
                    n_fail++;
                end else begin
                    e = results_q.pop_front();
                    if (m_tuser !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, m_tuser);
                        n_fail++;
                    end
                    if ($signed(m_tdata[cle_pkg::VAL_W-1:0]) !== e.value) begin
                        $error("result_value: expected %0d, got %0d", e.value,
                               $signed(m_tdata[cle_pkg::VAL_W-1:0]));
                        n_fail++;
                    end
                    if (m_tdata[cle_pkg::VAL_W+cle_pkg::INDEX_W-1:cle_pkg::VAL_W] !== e.index)
                    begin
                        $error("entry_index: expected %0d, got %0d", e.index,
                               m_tdata[cle_pkg::VAL_W+cle_pkg::INDEX_W-1:cle_pkg::VAL_W]);
                        n_fail++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("last: expected %0d, got %0d", e.last, m_tlast);
                        n_fail++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus sequence
    initial begin
        t_list_word w;

        // empty list cases
        word_q.push_back(make_word(cle_pkg::CMD_READ_OUT, 0, 0));
        word_q.push_back(make_word(cle_pkg::CMD_DEL_BEGIN, 0, 0));
        word_q.push_back(make_word(cle_pkg::CMD_DEL_END, 0, 0));
        word_q.push_back(make_word(cle_pkg::CMD_DEL_VALUE, 3, 0));
        word_q.push_back(make_word(cle_pkg::CMD_INS_POS, 5, 7));
        word_q.push_back(make_word(cle_pkg::CMD_DEL_END, 0, 0));
        // extreme values, head and position variants, past the end
        word_q.push_back(make_word(cle_pkg::CMD_INS_POS, 32'sh7FFF_FFFF, 8'd255));
        word_q.push_back(make_word(cle_pkg::CMD_INS_BEGIN, 32'sh8000_0000, 0));
        word_q.push_back(make_word(cle_pkg::CMD_INS_END, -1, 0));
        word_q.push_back(make_word(cle_pkg::CMD_INS_POS, 10, 0));
        word_q.push_back(make_word(cle_pkg::CMD_INS_POS, 11, 1));
        word_q.push_back(make_word(cle_pkg::CMD_INS_POS, 12, 2));
        word_q.push_back(make_word(cle_pkg::CMD_INS_POS, 13, 6));
        word_q.push_back(make_word(cle_pkg::CMD_INS_POS, 14, 8));
        word_q.push_back(make_word(cle_pkg::CMD_READ_OUT, 0, 0));
        // search misses, middle, tail and head hits
        word_q.push_back(make_word(cle_pkg::CMD_DEL_VALUE, 99, 0));
        word_q.push_back(make_word(cle_pkg::CMD_DEL_VALUE, 12, 0));
        word_q.push_back(make_word(cle_pkg::CMD_DEL_VALUE, 14, 0));
        word_q.push_back(make_word(cle_pkg::CMD_DEL_VALUE, 11, 0));
        word_q.push_back(make_word(cle_pkg::CMD_IGNORED, -1, 8'd255));
        word_q.push_back(make_word(cle_pkg::CMD_DEL_BEGIN, 0, 0));
        word_q.push_back(make_word(cle_pkg::CMD_DEL_END, 0, 0));
        word_q.push_back(make_word(cle_pkg::CMD_READ_OUT, 0, 0));
        word_q.push_back(make_word(cle_pkg::CMD_INS_END, 0, 0));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // no idling, one long output hold while words keep coming
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        rx_hold_asks = 1;
        for (int i = 0; i < 15; i++)
            word_q.push_back(rand_word(60));
        drain_words();

        // sparse sender, first word waits for all results
        tx_idle_pct = 66;
        rx_stall_pct = 0;
        for (int i = 0; i < 15; i++) begin
            w = rand_word(50);
            w.wait_drain = (i == 0);
            word_q.push_back(w);
        end
        drain_words();

        // slow receiver, fill the pool past full
        tx_idle_pct = 0;
        rx_stall_pct = 66;
        w = make_word(cle_pkg::CMD_READ_OUT, 0, 0);
        w.wait_drain = 1'b1;
        word_q.push_back(w);
        for (int i = 0; i < 34; i++)
            word_q.push_back(rand_word(100));
        word_q.push_back(make_word(cle_pkg::CMD_READ_OUT, 0, 0));
        drain_words();

        // both sides idle, mostly deletes
        tx_idle_pct = 23;
        rx_stall_pct = 23;
        for (int i = 0; i < 20; i++)
            word_q.push_back(rand_word(30));
        drain_words();

        while (results_q.size() > 0 || s_tvalid)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_fail == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/cle_pkg.sv
sv/cle_alloc.sv
sv/cle_store.sv
sv/cle_ctrl.sv
sv/circular_list_engine.sv
sv/cle_checker.sv
test/tb_circular_list_engine.sv
